[design/f32exp_pkg.sv]
package f32exp_pkg;

   // Number of register stages, one rounded float operation each
   localparam int NumStages = 19;

   // Float constants as bit patterns
   localparam logic [31:0] MagicBias  = 32'h4B400000;
   localparam logic [31:0] NegMagic   = 32'hCB400000;
   localparam logic [30:0] ZeroCutMag = 31'h42CFF1B4;
   localparam logic [30:0] InfCutMag  = 31'h42B17217;
   localparam logic [31:0] Log2e      = 32'h3FB8AA3B;
   localparam logic [31:0] NegLn2Hi   = 32'hBF317200;
   localparam logic [31:0] NegLn2Lo   = 32'hB5BFBE8E;
   localparam logic [31:0] Coef1      = 32'h3F7FFFFB;
   localparam logic [31:0] Coef2      = 32'h3EFFFEE3;
   localparam logic [31:0] Coef3      = 32'h3E2AAD40;
   localparam logic [31:0] Coef4      = 32'h3D2B9D0D;
   localparam logic [31:0] Coef5      = 32'h3C07CFCE;
   localparam logic [31:0] ExpMin     = 32'hC1000000;
   localparam logic [31:0] ExpMax     = 32'h3F800000;
   localparam logic [31:0] ExpOne     = 32'h3F800000;
   localparam logic [31:0] QuietNan   = 32'h7FC00000;
   localparam logic [31:0] PosInf     = 32'h7F800000;
   localparam logic [31:0] QuietBit   = 32'h00400000;

   // Stage numbers
   localparam int StMulLog2e = 0;
   localparam int StAddMagic = 1;
   localparam int StSubMagic = 2;
   localparam int StMulHi    = 3;
   localparam int StAddHi    = 4;
   localparam int StMulLo    = 5;
   localparam int StAddLo    = 6;
   localparam int StMulC5    = 7;
   localparam int StAddC4    = 8;
   localparam int StMul4     = 9;
   localparam int StAddC3    = 10;
   localparam int StMul3     = 11;
   localparam int StAddC2    = 12;
   localparam int StMul2     = 13;
   localparam int StAddC1    = 14;
   localparam int StMulSo    = 15;
   localparam int StMulTp    = 16;
   localparam int StAddSo    = 17;
   localparam int StMulSn    = 18;

   typedef struct packed {
      logic [31:0] x;
      logic        eob;
      logic        spec;
      logic [31:0] spec_y;
      logic [31:0] vn;
      logic [31:0] acc;
      logic [31:0] t;
      logic [31:0] p;
      logic [31:0] sn;
      logic [31:0] so;
   } stage_type;

   // Normalize, denormalize if needed, round to nearest-even and pack.
   // m has weight 2^(e-127) at bit 49.
   function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                              input logic [49:0] m);
      int                lz;
      int                sh;
      logic              found;
      logic [49:0]       mm;
      logic [49:0]       mask;
      logic              st0;
      logic              g;
      logic              st;
      logic [24:0]       mr;
      logic signed [10:0] ee;
      lz = 0;
      found = 1'b0;
      for (int i = 49; i >= 0; i--) begin
         if (m[i] && !found) begin
            lz = 49 - i;
            found = 1'b1;
         end
      end
      if (!found) return {s, 31'b0};
      mm = m << lz;
      ee = e - 11'(lz);
      // below normal range: shift into the denormal position
      if (ee < 11'sd1) begin
         sh = 1 - int'(ee);
         if (sh > 50) sh = 50;
         mask = ~({50{1'b1}} << sh);
         st0 = |(mm & mask);
         mm = (mm >> sh) | {49'b0, st0};
         ee = 11'sd1;
      end
      g = mm[25];
      st = |mm[24:0];
      mr = {1'b0, mm[49:26]};
      if (g && (st || mm[26])) mr = mr + 25'd1;
      if (mr[24]) begin
         mr = mr >> 1;
         ee = ee + 11'sd1;
      end
      if (ee >= 11'sd255) return {s, 8'hFF, 23'b0};
      if (!mr[23]) return {s, 8'h00, mr[22:0]};
      return {s, ee[7:0], mr[22:0]};
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      logic               s;
      logic               a_nan;
      logic               b_nan;
      logic               a_inf;
      logic               b_inf;
      logic               a_zero;
      logic               b_zero;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [7:0]         ea;
      logic [7:0]         eb;
      logic [47:0]        pr;
      logic signed [10:0] e;
      s = a[31] ^ b[31];
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf = (a[30:0] == 31'h7F800000);
      b_inf = (b[30:0] == 31'h7F800000);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      if (a_nan || b_nan) return QuietNan;
      if ((a_inf && b_zero) || (b_inf && a_zero)) return QuietNan;
      if (a_inf || b_inf) return {s, 8'hFF, 23'b0};
      if (a_zero || b_zero) return {s, 31'b0};
      ma = {(a[30:23] != 8'd0), a[22:0]};
      mb = {(b[30:23] != 8'd0), b[22:0]};
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      e = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
      pr = ma * mb;
      return round_pack(s, e, {pr, 2'b00});
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      logic               a_nan;
      logic               b_nan;
      logic               a_inf;
      logic               b_inf;
      logic [31:0]        lg;
      logic [31:0]        sm;
      logic [7:0]         el;
      logic [7:0]         es;
      int                 d;
      logic [49:0]        ml;
      logic [49:0]        ms;
      logic [49:0]        mask;
      logic               st;
      logic [49:0]        sum;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf = (a[30:0] == 31'h7F800000);
      b_inf = (b[30:0] == 31'h7F800000);
      if (a_nan || b_nan) return QuietNan;
      if (a_inf && b_inf && (a[31] != b[31])) return QuietNan;
      if (a_inf) return a;
      if (b_inf) return b;
      if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'b0};
      // larger magnitude first
      if (a[30:0] < b[30:0]) begin
         lg = b;
         sm = a;
      end else begin
         lg = a;
         sm = b;
      end
      el = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
      es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
      d = int'(el) - int'(es);
      if (d > 50) d = 50;
      ml = {1'b0, (lg[30:23] != 8'd0), lg[22:0], 25'b0};
      ms = {1'b0, (sm[30:23] != 8'd0), sm[22:0], 25'b0};
      mask = ~({50{1'b1}} << d);
      st = |(ms & mask);
      ms = (ms >> d) | {49'b0, st};
      sum = (lg[31] ^ sm[31]) ? (ml - ms) : (ml + ms);
      if (sum == 50'd0) return 32'h0;
      return round_pack(lg[31], $signed({3'b0, el}) + 11'sd1, sum);
   endfunction

   // Work done by one pipeline stage
   function automatic stage_type stage_op(input int idx, input stage_type s);
      stage_type   r;
      logic        nan;
      logic [31:0] sh;
      logic [31:0] en;
      logic [31:0] eo;
      r = s;
      case (idx)
         StMulLog2e: begin
            nan = (s.x[30:23] == 8'hFF) && (s.x[22:0] != 23'd0);
            r.spec = 1'b1;
            if (nan) r.spec_y = s.x | QuietBit;
            else if (s.x[31] && (s.x[30:0] > ZeroCutMag)) r.spec_y = 32'h0;
            else if (!s.x[31] && (s.x[30:0] > InfCutMag)) r.spec_y = PosInf;
            else begin
               r.spec = 1'b0;
               r.spec_y = 32'h0;
            end
            r.acc = fmul(s.x, Log2e);
         end
         StAddMagic: r.vn = fadd(s.acc, MagicBias);
         StSubMagic: begin
            // exponent scale split from the biased n
            sh = {s.vn[8:0], 23'b0};
            en = sh;
            if ($signed(en) < $signed(ExpMin)) en = ExpMin;
            if ($signed(ExpMax) < $signed(en)) en = ExpMax;
            eo = sh - en;
            r.sn = en + ExpOne;
            r.so = eo + ExpOne;
            r.vn = fadd(s.vn, NegMagic);
         end
         StMulHi:    r.acc = fmul(s.vn, NegLn2Hi);
         StAddHi:    r.t = fadd(s.acc, s.x);
         StMulLo:    r.acc = fmul(s.vn, NegLn2Lo);
         StAddLo:    r.t = fadd(s.acc, s.t);
         StMulC5:    r.p = fmul(Coef5, s.t);
         StAddC4:    r.p = fadd(s.p, Coef4);
         StMul4:     r.p = fmul(s.p, s.t);
         StAddC3:    r.p = fadd(s.p, Coef3);
         StMul3:     r.p = fmul(s.p, s.t);
         StAddC2:    r.p = fadd(s.p, Coef2);
         StMul2:     r.p = fmul(s.p, s.t);
         StAddC1:    r.p = fadd(s.p, Coef1);
         StMulSo:    r.t = fmul(s.t, s.so);
         StMulTp:    r.acc = fmul(s.t, s.p);
         StAddSo:    r.acc = fadd(s.acc, s.so);
         StMulSn:    r.acc = s.spec ? s.spec_y : fmul(s.sn, s.acc);
         default:    r = s;
      endcase
      return r;
   endfunction

endpackage

[design/f32_exp_polynomial_core.sv]
// Single-precision exp(x), one value per transaction.
// Request channel: req_valid/req_ready carry req_x_bits (IEEE single) and
// req_end_of_block, a mark that comes back unchanged on the result.
// Response channel: rsp_valid/rsp_ready carry rsp_y_bits = exp(x) and
// rsp_end_of_block_out.
// The datapath is a 19-stage pipeline, one rounded float multiply or add per
// stage, each stage ending in a register; a new transaction can be taken
// every cycle unless every stage is occupied and rsp_ready is low.
// NaN inputs return quieted; large negative inputs give +0, large positive
// inputs give +inf.
// Each stage holds its transaction while the next is full and held, so a
// stall on rsp_ready fills the empty stages first; req_ready falls only
// when every stage is occupied. Nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline; results in flight
// are discarded.
module f32_exp_polynomial_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_x_bits,
   input  logic        req_end_of_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_y_bits,
   output logic        rsp_end_of_block_out
);

   localparam int N = f32exp_pkg::NumStages;

   logic                  valid_w [N+1];
   logic                  ready_w [N+1];
   f32exp_pkg::stage_type data_w  [N+1];
   f32exp_pkg::stage_type req_data;

   // input transaction enters stage 0
   always_comb begin
      req_data        = '0;
      req_data.x      = req_x_bits;
      req_data.eob    = req_end_of_block;
   end
   assign data_w[0]  = req_data;
   assign valid_w[0] = req_valid;
   assign req_ready  = ready_w[0];

   for (genvar k = 0; k < N; k++) begin : g_stage
      f32exp_stage #(
         .StageIdx(k)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid_w[k]),
         .in_ready (ready_w[k]),
         .in_data  (data_w[k]),
         .out_valid(valid_w[k+1]),
         .out_ready(ready_w[k+1]),
         .out_data (data_w[k+1])
      );
   end

   // last stage drives the response
   assign ready_w[N]           = rsp_ready;
   assign rsp_valid            = valid_w[N];
   assign rsp_y_bits           = data_w[N].acc;
   assign rsp_end_of_block_out = data_w[N].eob;

endmodule

[design/f32exp_stage.sv]
module f32exp_stage #(
   parameter int StageIdx = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  f32exp_pkg::stage_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output f32exp_pkg::stage_type out_data
);

   logic                  valid_ff;
   f32exp_pkg::stage_type data_ff;
   f32exp_pkg::stage_type data_in;

   // stage takes a transaction when empty or when its own is moving on
   assign in_ready = !valid_ff || out_ready;
   assign data_in  = f32exp_pkg::stage_op(StageIdx, in_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[test/f32_exp_polynomial_checker.sv]
// Watches both channels of the exp core, predicts each result and
// compares it with what comes out.
module f32_exp_polynomial_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_x_bits,
   input  logic        req_end_of_block,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_y_bits,
   input  logic        rsp_end_of_block_out,
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct {
      logic [31:0] y;
      logic        eob;
   } exp_result_type;

   exp_result_type expected_results[$];

   // Round m * 2^e to single precision, nearest-even, denormals kept
   function automatic logic [31:0] f_round(input logic s, input int e,
                                           input logic [127:0] m);
      int           msb;
      int           ex;
      int           sh;
      logic [127:0] r;
      logic [127:0] rem;
      logic [127:0] half;
      logic         normal;
      if (m == 128'd0) return {s, 31'd0};
      msb = 0;
      for (int i = 0; i < 128; i++) if (m[i]) msb = i;
      ex = msb + e;
      normal = (ex + 127 >= 1);
      sh = normal ? msb - 23 : -149 - e;
      if (sh > 127) begin
         r = 128'd0;
         rem = 128'd1;
         half = 128'd2;
      end else if (sh > 0) begin
         r = m >> sh;
         rem = m & ((128'd1 << sh) - 128'd1);
         half = 128'd1 << (sh - 1);
      end else begin
         r = m << (-sh);
         rem = 128'd0;
         half = 128'd1;
      end
      if (rem > half || (rem == half && r[0])) r = r + 128'd1;
      if (!normal) return {s, r[30:0]};
      if (r[24]) begin
         r = r >> 1;
         ex = ex + 1;
      end
      if (ex + 127 >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(ex + 127), r[22:0]};
   endfunction

   function automatic logic is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
      logic         s;
      logic [127:0] ma;
      logic [127:0] mb;
      int           ea;
      int           eb;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return f32exp_pkg::QuietNan;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return f32exp_pkg::QuietNan;
         return {s, 8'hFF, 23'd0};
      end
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
      ma = {104'd0, (a[30:23] != 8'd0), a[22:0]};
      mb = {104'd0, (b[30:23] != 8'd0), b[22:0]};
      ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
      eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
      return f_round(s, ea + eb - 300, ma * mb);
   endfunction

   function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]  big;
      logic [31:0]  tiny;
      int           eb;
      int           et;
      int           d;
      logic [127:0] wb;
      logic [127:0] wt;
      logic         st;
      logic [127:0] sum;
      if (is_nan(a) || is_nan(b)) return f32exp_pkg::QuietNan;
      if (a[30:0] == 31'h7F800000 && b[30:0] == 31'h7F800000 && a[31] != b[31])
         return f32exp_pkg::QuietNan;
      if (a[30:0] == 31'h7F800000) return a;
      if (b[30:0] == 31'h7F800000) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      if (a[30:0] < b[30:0]) begin
         big = b;
         tiny = a;
      end else begin
         big = a;
         tiny = b;
      end
      eb = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
      et = (tiny[30:23] == 8'd0) ? 1 : int'(tiny[30:23]);
      d = eb - et;
      wb = {104'd0, (big[30:23] != 8'd0), big[22:0]} << 40;
      wt = {104'd0, (tiny[30:23] != 8'd0), tiny[22:0]} << 40;
      // far-off operand only leaves a sticky bit
      if (d > 100) begin
         wt = {127'd0, wt != 128'd0};
      end else begin
         st = (wt & ((128'd1 << d) - 128'd1)) != 128'd0;
         wt = (wt >> d) | {127'd0, st};
      end
      sum = (big[31] ^ tiny[31]) ? wb - wt : wb + wt;
      if (sum == 128'd0) return 32'd0;
      return f_round(big[31], eb - 190, sum);
   endfunction

   // exp(x) on raw single-precision patterns
   function automatic logic [31:0] exp_predict(input logic [31:0] xb);
      logic [31:0] vn;
      logic [31:0] shifted;
      logic [31:0] en;
      logic [31:0] eo;
      logic [31:0] sn;
      logic [31:0] so;
      logic [31:0] t;
      logic [31:0] p;
      if (is_nan(xb)) return xb | f32exp_pkg::QuietBit;
      if (xb[31] && xb[30:0] > f32exp_pkg::ZeroCutMag) return 32'd0;
      if (!xb[31] && xb[30:0] > f32exp_pkg::InfCutMag) return f32exp_pkg::PosInf;
      vn = f_add(f_mul(xb, f32exp_pkg::Log2e), f32exp_pkg::MagicBias);
      shifted = vn << 23;
      en = shifted;
      if ($signed(en) < $signed(f32exp_pkg::ExpMin)) en = f32exp_pkg::ExpMin;
      if ($signed(f32exp_pkg::ExpMax) < $signed(en)) en = f32exp_pkg::ExpMax;
      eo = shifted - en;
      sn = en + f32exp_pkg::ExpOne;
      so = eo + f32exp_pkg::ExpOne;
      vn = f_add(vn, f32exp_pkg::NegMagic);
      t = f_add(f_mul(vn, f32exp_pkg::NegLn2Hi), xb);
      t = f_add(f_mul(vn, f32exp_pkg::NegLn2Lo), t);
      p = f_add(f_mul(f32exp_pkg::Coef5, t), f32exp_pkg::Coef4);
      p = f_add(f_mul(p, t), f32exp_pkg::Coef3);
      p = f_add(f_mul(p, t), f32exp_pkg::Coef2);
      p = f_add(f_mul(p, t), f32exp_pkg::Coef1);
      t = f_mul(t, so);
      return f_mul(sn, f_add(f_mul(t, p), so));
   endfunction

   // predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      exp_result_type want;
      int             bad;
      bad = 0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want.y = exp_predict(req_x_bits);
            want.eob = req_end_of_block;
            expected_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected transaction: y_bits=%h", rsp_y_bits);
               bad++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_y_bits !== want.y) begin
                  $error("y_bits: expected %h, got %h", want.y, rsp_y_bits);
                  bad++;
               end
               if (rsp_end_of_block_out !== want.eob) begin
                  $error("end_of_block_out: expected %b, got %b", want.eob,
                         rsp_end_of_block_out);
                  bad++;
               end
            end
         end
      end
      mismatch_count <= mismatch_count + bad;
      pending_count <= expected_results.size();
   end

endmodule

[test/tb_f32_exp_polynomial_core.sv]
module tb_f32_exp_polynomial_core;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_x_bits = 32'd0;
   logic        req_end_of_block = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_y_bits;
   logic        rsp_end_of_block_out;
   int          mismatch_count;
   int          pending_count;

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_go = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;

   always #2 clock = ~clock;

   f32_exp_polynomial_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_bits(req_x_bits), .req_end_of_block(req_end_of_block),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_y_bits(rsp_y_bits), .rsp_end_of_block_out(rsp_end_of_block_out)
   );

   f32_exp_polynomial_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_bits(req_x_bits), .req_end_of_block(req_end_of_block),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_y_bits(rsp_y_bits), .rsp_end_of_block_out(rsp_end_of_block_out),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= 80;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one transaction, with random idle cycles ahead of it
   task automatic send_x(input logic [31:0] x, input logic eob);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_bits <= x;
      req_end_of_block <= eob;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || req_valid) @(posedge clock);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // mostly in-range values, some near the cutoffs, the rest raw patterns
   function automatic logic [31:0] random_x();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55)
         return {1'($urandom), 8'($urandom_range(133, 96)), 23'($urandom)};
      if (sel < 65)
         return {1'($urandom), 8'($urandom_range(95, 0)), 23'($urandom)};
      if (sel < 75)
         return 32'h42B17217 + 32'($urandom_range(8)) - 32'd4;
      if (sel < 85)
         return 32'hC2CFF1B4 + 32'($urandom_range(8)) - 32'd4;
      return $urandom;
   endfunction

   logic [31:0] directed_x[] = '{
      32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
      32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'hFFC00001,
      32'h42B17217, 32'h42B17218, 32'hC2CFF1B4, 32'hC2CFF1B5,
      32'h3F800000, 32'hBF800000, 32'h00000001, 32'h80000001,
      32'h42A00000, 32'hC2C80000, 32'hC2AF0000, 32'h42B17200,
      32'hC2CE0000, 32'h3F317218, 32'h7F7FFFFF, 32'hFF7FFFFF
   };

   int send_pcts[4] = '{0, 72, 0, 26};
   int stall_pcts[4] = '{0, 0, 72, 26};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed values
      foreach (directed_x[i]) send_x(directed_x[i], 1'(i));

      // receiver holds off while the sender keeps offering
      hold_go <= ~hold_go;
      repeat (40) send_x(random_x(), 1'($urandom));
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_pcts[ph];
         stall_pct = stall_pcts[ph];
         repeat (400) send_x(random_x(), 1'($urandom));
      end
      send_idle_pct = 0;
      stall_pct = 0;
      drain_results();
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("f32_exp_polynomial_core regression: pass");
      end else begin
         $display("f32_exp_polynomial_core regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("f32_exp_polynomial_core regression: fail");
      $finish;
   end

endmodule

[files.f]
design/f32exp_pkg.sv
design/f32exp_stage.sv
design/f32_exp_polynomial_core.sv
test/f32_exp_polynomial_checker.sv
test/tb_f32_exp_polynomial_core.sv
